// File: src/anem_pkg.sv
// Shared types, constants and helper functions for the wind sensor interface.
// Used by anem_ctrl, anem_dp and anemometer_speed_direction_top; no dependencies.
package anem_pkg;

	// Widths of the stored counters and arithmetic words.
	localparam int TIME_W   = 32;
	localparam int DEB_W    = 10;
	localparam int SCALE_W  = 20;
	localparam int MV_W     = 12;
	localparam int SPEED_W  = 16;
	localparam int DEG_W    = 9;
	localparam int PROD_W   = TIME_W + SCALE_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SCALE_W;
	localparam int LEVELS   = 8;
	localparam int LVL_IDX_W = $clog2(LEVELS);
	localparam int DIV_CNT_W = $clog2(SPEED_W);

	// Register reset values and the saturated speed.
	localparam logic [DEB_W-1:0]   DEBOUNCE_RST = DEB_W'(15);
	localparam logic [SCALE_W-1:0] SCALE_RST    = SCALE_W'(47941);
	localparam logic [SPEED_W-1:0] SPEED_MAX    = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 1'b1;

	// Input command codes.
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_EDGE   = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_code_t;

	// Vane voltage levels in mV and the matching heading in degrees.
	localparam logic [MV_W-1:0] VANE_MV [LEVELS] = '{
		12'd900, 12'd2000, 12'd3000, 12'd2800, 12'd2500, 12'd1500, 12'd300, 12'd600
	};
	localparam logic [DEG_W-1:0] VANE_DEG [LEVELS] = '{
		9'd0, 9'd45, 9'd90, 9'd135, 9'd180, 9'd225, 9'd270, 9'd315
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic do_tick;
		logic do_edge;
		logic do_sample;
		logic do_mul;
		logic do_sat;
		logic do_div;
		logic load_out;
	} anem_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic delta_zero;
		logic sat;
	} anem_stat_t;

	// Index of the nearest vane level; the lowest index wins a tie.
	function automatic logic [LVL_IDX_W-1:0] nearest_idx(input logic [MV_W-1:0] mv);
		logic [LVL_IDX_W-1:0] best;
		logic [MV_W:0]        best_dist;
		logic [MV_W-1:0]      diff;
		best      = '0;
		best_dist = '1;
		for (int i = 0; i < LEVELS; i++) begin
			diff = (VANE_MV[i] >= mv) ? (VANE_MV[i] - mv) : (mv - VANE_MV[i]);
			if ({1'b0, diff} < best_dist) begin
				best_dist = {1'b0, diff};
				best      = LVL_IDX_W'(i);
			end
		end
		return best;
	endfunction

endpackage

// File: src/anem_ctrl.sv
// Controller state machine for the wind sensor interface.
// Depends on anem_pkg; drives anem_dp through command and status structs.
module anem_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [1:0]           cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output anem_pkg::anem_cmd_t  dp_cmd,
	input  anem_pkg::anem_stat_t dp_stat
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_SAT  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t                             state_q, state_d;
	logic [anem_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                               res_valid_q;
	logic                               accept;
	logic                               out_free;

	// A new transaction is taken only between sample computations.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign res_valid  = res_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d          = state_q;
		dp_cmd           = '0;
		dp_cmd.do_tick   = accept && (cmd == anem_pkg::CMD_TICK);
		dp_cmd.do_edge   = accept && (cmd == anem_pkg::CMD_EDGE);
		dp_cmd.do_sample = accept && (cmd == anem_pkg::CMD_SAMPLE);
		unique case (state_q)
			ST_IDLE: begin
				if (dp_cmd.do_sample) begin
					state_d = dp_stat.delta_zero ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL: begin
				dp_cmd.do_mul = 1'b1;
				state_d       = ST_SAT;
			end
			ST_SAT: begin
				dp_cmd.do_sat = 1'b1;
				state_d       = dp_stat.sat ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				dp_cmd.do_div = 1'b1;
				if (cnt_q == anem_pkg::DIV_CNT_W'(anem_pkg::SPEED_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					dp_cmd.load_out = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, divide step counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.do_div) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (dp_cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// The step counter only runs while dividing.
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (cnt_q == '0))
		else $error("divide counter nonzero outside divide");

	// The product is always followed by the saturation check.
	a_mul_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_SAT))
		else $error("saturation check skipped");

	// A result is never loaded over one that is still stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_out |-> (!res_valid_q || !res_stall))
		else $error("result overwritten while stalled");

	// A sample with nonzero interval starts the multiply.
	a_sample_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.do_sample && !dp_stat.delta_zero) |=> (state_q == ST_MUL))
		else $error("sample did not start computation");

endmodule

// File: src/anem_dp.sv
// Datapath for the wind sensor interface: counters, registers, multiply,
// saturation check, restoring divider and result registers. Depends on anem_pkg.
module anem_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [anem_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [anem_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic [anem_pkg::MV_W-1:0]            dir_mv,
	input  anem_pkg::anem_cmd_t                  dp_cmd,
	output anem_pkg::anem_stat_t                 dp_stat,
	output logic                                 valid_res,
	output logic [anem_pkg::SPEED_W-1:0]         wind_speed,
	output logic [anem_pkg::DEG_W-1:0]           direction_deg
);

	logic [anem_pkg::DEB_W-1:0]     debounce_q;
	logic [anem_pkg::SCALE_W-1:0]   scale_q;
	logic [anem_pkg::TIME_W-1:0]    time_q;
	logic [anem_pkg::TIME_W-1:0]    last_edge_q;
	logic [anem_pkg::TIME_W-1:0]    last_sample_q;
	logic [anem_pkg::TIME_W-1:0]    pulse_q;
	logic [anem_pkg::TIME_W-1:0]    pc_q;
	logic [anem_pkg::TIME_W-1:0]    delta_q;
	logic [anem_pkg::MV_W-1:0]      mv_q;
	logic [anem_pkg::LVL_IDX_W-1:0] idx_q;
	logic [anem_pkg::PROD_W-1:0]    prod_q;
	logic [anem_pkg::TIME_W-1:0]    rem_q;
	logic [anem_pkg::SPEED_W-1:0]   quo_q;
	logic                           zero_q;
	logic                           sat_q;
	logic                           valid_res_q;
	logic [anem_pkg::SPEED_W-1:0]   speed_q;
	logic [anem_pkg::DEG_W-1:0]     deg_q;

	logic [anem_pkg::TIME_W-1:0]    delta;
	logic [anem_pkg::TIME_W-1:0]    edge_gap;
	logic                           edge_ok;
	logic [anem_pkg::PROD_W-anem_pkg::SPEED_W-1:0] prod_hi;
	logic [anem_pkg::TIME_W:0]      trial;
	logic                           qbit;

	// Interval since the last sample and spacing since the last counted edge.
	assign delta    = time_q - last_sample_q;
	assign edge_gap = time_q - last_edge_q;
	assign edge_ok  = edge_gap > anem_pkg::TIME_W'(debounce_q);
	assign dp_stat.delta_zero = (delta == '0);

	// Speed saturates when the product reaches delta times 2^16.
	assign prod_hi     = prod_q[anem_pkg::PROD_W-1:anem_pkg::SPEED_W];
	assign dp_stat.sat = prod_hi >= (anem_pkg::PROD_W - anem_pkg::SPEED_W)'(delta_q);

	// One restoring divide step: bring down the next dividend bit.
	assign trial = {rem_q, quo_q[anem_pkg::SPEED_W-1]};
	assign qbit  = trial >= {1'b0, delta_q};

	// Configuration registers and the sensor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= anem_pkg::DEBOUNCE_RST;
			scale_q       <= anem_pkg::SCALE_RST;
			time_q        <= '0;
			last_edge_q   <= '0;
			last_sample_q <= '0;
			pulse_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					anem_pkg::REG_DEBOUNCE: debounce_q <= cfg_wdata[anem_pkg::DEB_W-1:0];
					anem_pkg::REG_SCALE:    scale_q    <= cfg_wdata;
					default: ;
				endcase
			end
			if (dp_cmd.do_tick) begin
				time_q <= time_q + 1'b1;
			end
			if (dp_cmd.do_edge && edge_ok) begin
				pulse_q     <= pulse_q + 1'b1;
				last_edge_q <= time_q;
			end
			if (dp_cmd.do_sample && !dp_stat.delta_zero) begin
				pulse_q       <= '0;
				last_sample_q <= time_q;
			end
		end
	end

	// Sample capture, product, saturation check, divide iterations and result load.
	always_ff @(posedge clk) begin
		if (dp_cmd.do_sample) begin
			zero_q  <= dp_stat.delta_zero;
			pc_q    <= pulse_q;
			delta_q <= delta;
			mv_q    <= dir_mv;
		end
		if (dp_cmd.do_mul) begin
			prod_q <= anem_pkg::PROD_W'(pc_q) * anem_pkg::PROD_W'(scale_q);
			idx_q  <= anem_pkg::nearest_idx(mv_q);
		end
		if (dp_cmd.do_sat) begin
			// Below saturation the upper part is smaller than delta, so it fits.
			sat_q <= dp_stat.sat;
			rem_q <= prod_hi[anem_pkg::TIME_W-1:0];
			quo_q <= prod_q[anem_pkg::SPEED_W-1:0];
		end
		if (dp_cmd.do_div) begin
			rem_q <= qbit ? anem_pkg::TIME_W'(trial - {1'b0, delta_q})
			              : trial[anem_pkg::TIME_W-1:0];
			quo_q <= {quo_q[anem_pkg::SPEED_W-2:0], qbit};
		end
		if (dp_cmd.load_out) begin
			valid_res_q <= !zero_q;
			speed_q     <= zero_q ? '0 : (sat_q ? anem_pkg::SPEED_MAX : quo_q);
			deg_q       <= zero_q ? '0 : anem_pkg::VANE_DEG[idx_q];
		end
	end

	assign valid_res     = valid_res_q;
	assign wind_speed    = speed_q;
	assign direction_deg = deg_q;

endmodule

// File: src/anemometer_speed_direction_top.sv
// Wind sensor interface top level: cup anemometer pulse counter and vane decoder.
// Tick, edge and unused commands give no result. A sample with a zero interval goes
// straight to the result load; a saturated speed first runs the multiply and saturation
// check; any other sample runs multiply, saturation check and 16 restoring divide steps,
// then the result load. The input stalls until the load, which waits out any output stall.
// Asynchronous active-low reset clears all counters and restores register defaults.
module anemometer_speed_direction_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [anem_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [anem_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [1:0]                         cmd,
	input  logic [anem_pkg::MV_W-1:0]          dir_mv,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic                               valid_res,
	output logic [anem_pkg::SPEED_W-1:0]       wind_speed,
	output logic [anem_pkg::DEG_W-1:0]         direction_deg
);

	anem_pkg::anem_cmd_t  dp_cmd;
	anem_pkg::anem_stat_t dp_stat;

	// Sequencing of each transaction.
	anem_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.dp_cmd     (dp_cmd),
		.dp_stat    (dp_stat)
	);

	// Counters, arithmetic and result registers.
	anem_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.dir_mv        (dir_mv),
		.dp_cmd        (dp_cmd),
		.dp_stat       (dp_stat),
		.valid_res     (valid_res),
		.wind_speed    (wind_speed),
		.direction_deg (direction_deg)
	);

endmodule

// File: bench/tb.sv
// Self-checking testbench for anemometer_speed_direction_top: directed and random command
// streams, an in-order prediction of speed and direction, and random flow control.
// Depends on anem_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
	import anem_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_TXNS    = 275;
	localparam int PHASES        = 6;
	localparam int HOLD_AT       = 30;
	localparam int HOLD_CYCLES   = 400;
	localparam int LEVEL_MV [8]  = '{900, 2000, 3000, 2800, 2500, 1500, 300, 600};

	// One command transaction and one wind reading.
	typedef struct {
		cmd_code_t         code;
		logic [MV_W-1:0]   mv;
	} sensor_txn_t;

	typedef struct {
		logic               ok;
		logic [SPEED_W-1:0] speed;
		logic [DEG_W-1:0]   deg;
	} wind_reading_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = REG_DEBOUNCE;
	logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic [1:0]            cmd        = CMD_TICK;
	logic [MV_W-1:0]       dir_mv     = '0;
	logic                  res_valid;
	logic                  res_stall  = 1'b0;
	logic                  valid_res;
	logic [SPEED_W-1:0]    wind_speed;
	logic [DEG_W-1:0]      direction_deg;

	// Sensor state as the block should hold it.
	logic [TIME_W-1:0]  clock_ms;
	logic [TIME_W-1:0]  last_edge_ms;
	logic [TIME_W-1:0]  last_sample_ms;
	logic [TIME_W-1:0]  pulse_total;
	logic [DEB_W-1:0]   debounce_set;
	logic [SCALE_W-1:0] scale_set;

	sensor_txn_t   stim_txns [$];
	wind_reading_t readings_due [$];
	sensor_txn_t   shown_txn;

	int queued_txns   = 0;
	int accepted_txns = 0;
	int readings_seen = 0;
	int mismatches    = 0;
	int cycle_count   = 0;
	int gap_left      = 0;
	int send_calm     = 0;
	int stall_left    = 0;
	int recv_calm     = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;

	anemometer_speed_direction_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.cmd           (cmd),
		.dir_mv        (dir_mv),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.valid_res     (valid_res),
		.wind_speed    (wind_speed),
		.direction_deg (direction_deg)
	);

	always #5 clk = ~clk;

	// Index of the closest vane level; the lower index keeps a tie.
	function automatic int vane_sector(input int mv);
		int best;
		int best_dist;
		int diff;
		best      = 0;
		best_dist = 1 << 30;
		for (int i = 0; i < 8; i++) begin
			diff = (LEVEL_MV[i] >= mv) ? LEVEL_MV[i] - mv : mv - LEVEL_MV[i];
			if (diff < best_dist) begin
				best_dist = diff;
				best      = i;
			end
		end
		return best;
	endfunction

	// Wait count for one side, with occasional stretches of back-to-back transfers.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 5);
	endfunction

	// Apply one accepted command to the expected sensor state.
	task automatic update_wind_state(input sensor_txn_t txn);
		logic [TIME_W-1:0] span;
		logic [63:0]       quotient;
		wind_reading_t     r;
		case (txn.code)
			CMD_TICK: clock_ms = clock_ms + 1;
			CMD_EDGE: begin
				span = clock_ms - last_edge_ms;
				if (span > TIME_W'(debounce_set)) begin
					pulse_total  = pulse_total + 1;
					last_edge_ms = clock_ms;
				end
			end
			CMD_SAMPLE: begin
				span = clock_ms - last_sample_ms;
				if (span == '0) begin
					r = '{1'b0, '0, '0};
				end else begin
					quotient = (64'(pulse_total) * 64'(scale_set)) / 64'(span);
					r.ok     = 1'b1;
					r.speed  = (quotient > 64'(SPEED_MAX)) ? SPEED_MAX : quotient[SPEED_W-1:0];
					r.deg    = DEG_W'(vane_sector(int'(txn.mv)) * 45);
					pulse_total    = '0;
					last_sample_ms = clock_ms;
				end
				readings_due.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic queue_txn(input cmd_code_t code, input logic [MV_W-1:0] mv);
		sensor_txn_t t;
		t.code = code;
		t.mv   = mv;
		stim_txns.push_back(t);
		queued_txns++;
	endtask

	// Vane voltage: uniform, or close to one of the levels.
	function automatic logic [MV_W-1:0] vane_mv();
		int v;
		if ($urandom_range(0, 1) == 0)
			return MV_W'($urandom);
		v = LEVEL_MV[$urandom_range(0, 7)] + $urandom_range(0, 60) - 30;
		return MV_W'(v);
	endfunction

	// A measurement interval: ticks with edges, then a sample; sometimes plain noise.
	task automatic queue_burst(output int added);
		added = 0;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(4, 20)) begin
				queue_txn(cmd_code_t'($urandom_range(0, 3)), MV_W'($urandom));
				added++;
			end
		end else begin
			repeat ($urandom_range(1, 20)) begin
				queue_txn(CMD_TICK, MV_W'($urandom));
				added++;
				repeat ($urandom_range(0, 2)) begin
					queue_txn(CMD_EDGE, MV_W'($urandom));
					added++;
				end
				if ($urandom_range(0, 24) == 0) begin
					queue_txn(CMD_NONE, MV_W'($urandom));
					added++;
				end
			end
			queue_txn(CMD_SAMPLE, vane_mv());
			added++;
			// A second sample at the same millisecond sees a zero interval.
			if ($urandom_range(0, 7) == 0) begin
				queue_txn(CMD_SAMPLE, vane_mv());
				added++;
			end
		end
	endtask

	// Both registers are written back to back while the block is idle.
	task automatic write_config(input logic [DEB_W-1:0] deb, input logic [SCALE_W-1:0] scale);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_wdata <= {10'($urandom), deb};
		debounce_set = deb;
		@(posedge clk);
		cfg_index <= REG_SCALE;
		cfg_wdata <= scale;
		scale_set = scale;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sender stops until every queued transaction is taken and every reading is back.
	task automatic wait_for_quiet();
		while (accepted_txns != queued_txns || readings_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Command driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				update_wind_state(shown_txn);
				accepted_txns++;
			end
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (stim_txns.size() != 0) begin
					shown_txn = stim_txns.pop_front();
					cmd        <= shown_txn.code;
					dir_mv     <= shown_txn.mv;
					item_valid <= 1'b1;
					gap_left = draw_wait(send_calm);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Reading monitor and receiver flow control.
	always @(posedge clk) begin
		wind_reading_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (readings_due.size() == 0) begin
					$display("%0t: unexpected reading valid=%0b speed=%0d dir=%0d",
						$time, valid_res, wind_speed, direction_deg);
					mismatches++;
				end else begin
					want = readings_due.pop_front();
					if (valid_res !== want.ok) begin
						$display("%0t: valid_res expected %0b actual %0b",
							$time, want.ok, valid_res);
						mismatches++;
					end
					if (wind_speed !== want.speed) begin
						$display("%0t: wind_speed expected %0d actual %0d",
							$time, want.speed, wind_speed);
						mismatches++;
					end
					if (direction_deg !== want.deg) begin
						$display("%0t: direction_deg expected %0d actual %0d",
							$time, want.deg, direction_deg);
						mismatches++;
					end
				end
				readings_seen++;
				stall_left = draw_wait(recv_calm);
				// One long hold-off so the block backs up into its command input.
				if (!hold_done && readings_seen == HOLD_AT) begin
					hold_done = 1'b1;
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("anemometer_speed_direction_top test failed");
			$finish;
		end
	end

	// Reset, directed checks, then random phases under several register settings.
	initial begin
		int phase_txns;
		int added;
		clock_ms       = '0;
		last_edge_ms   = '0;
		last_sample_ms = '0;
		pulse_total    = '0;
		debounce_set   = DEBOUNCE_RST;
		scale_set      = SCALE_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero interval right after reset, an early edge, the unused command.
		queue_txn(CMD_SAMPLE, 12'd0);
		queue_txn(CMD_EDGE, 12'd0);
		queue_txn(CMD_NONE, 12'hFFF);
		queue_txn(CMD_TICK, 12'hFFF);
		queue_txn(CMD_TICK, 12'd0);
		queue_txn(CMD_EDGE, 12'hFFF);
		queue_txn(CMD_SAMPLE, 12'hFFF);
		queue_txn(CMD_SAMPLE, 12'hFFF);
		wait_for_quiet();

		// No debounce and the largest scale: saturated speed, then the tie points.
		write_config(10'd0, 20'hFFFFF);
		queue_txn(CMD_TICK, 12'd0);
		queue_txn(CMD_EDGE, 12'd0);
		queue_txn(CMD_EDGE, 12'd0);
		queue_txn(CMD_TICK, 12'd0);
		queue_txn(CMD_EDGE, 12'd0);
		queue_txn(CMD_SAMPLE, 12'd750);
		foreach (LEVEL_MV[i]) begin
			if (i > 0) begin
				queue_txn(CMD_TICK, 12'd0);
				queue_txn(CMD_SAMPLE, MV_W'(i == 1 ? 1750 : i == 2 ? 2900 : i == 3 ? 2650 :
					i == 6 ? 450 : LEVEL_MV[i]));
			end
		end
		wait_for_quiet();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_config(10'd0, 20'd47941);
				1: write_config(10'd1000, 20'hFFFFF);
				2: write_config(10'd0, 20'd0);
				3: write_config(10'd3, 20'($urandom_range(1, 200000)));
				4: write_config(10'($urandom_range(0, 40)), 20'($urandom));
				default: write_config(DEBOUNCE_RST, SCALE_RST);
			endcase
			phase_txns = 0;
			while (phase_txns < PHASE_TXNS) begin
				queue_burst(added);
				phase_txns += added;
			end
			wait_for_quiet();
		end

		if (mismatches == 0)
			$display("anemometer_speed_direction_top test passed");
		else
			$display("anemometer_speed_direction_top test failed");
		$finish;
	end

endmodule
